// ===== hdl/ellipse_point_generator_assert.svh =====
// assertion macros used by the checker file of the ellipse point generator
`ifndef ELLIPSE_POINT_GENERATOR_ASSERT_SVH
`define ELLIPSE_POINT_GENERATOR_ASSERT_SVH

// property checked on every clock edge outside reset
`define EPG_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ellipse point generator check failed");

// property checked on every clock edge, reset included
`define EPG_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("ellipse point generator check failed");

`endif

// ===== hdl/epg_pkg.sv =====
// shared types and constants of the ellipse point generator
package epg_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEFAULT = 8;

   // action codes carried on the request tuser bit
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // index of the fourth mirrored point of a step
   localparam logic [1:0] LAST_POINT = 2'd3;

   // drawing region
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_R1,
      PH_R2
   } phase_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_READY,
      ST_S_RX2,
      ST_S_RY2,
      ST_S_T,
      ST_S_P,
      ST_S_DIV,
      ST_STEP_LOAD,
      ST_R1_A,
      ST_R1_B,
      ST_R1_C,
      ST_R2_A,
      ST_R2_B,
      ST_R2_C,
      ST_E_A,
      ST_E_B,
      ST_E_C,
      ST_E_D,
      ST_E_E,
      ST_E_F,
      ST_E_G
   } seq_state_type;

   // operations of the decision accumulator
   typedef enum logic [3:0] {
      ADD_HOLD,
      ADD_ZERO,
      ADD_RX2,
      ADD_RY2,
      ADD_PX,
      ADD_NEG_PY,
      ADD_PROD,
      ADD_PROD4,
      ADD_NEG_PROD4,
      ADD_DIV
   } add_op_type;

endpackage

// ===== hdl/epg_mult.sv =====
// shared signed multiplier with a registered product
module epg_mult #(
   parameter int WIDTH = 2 * epg_pkg::COORD_BITS_DEFAULT + 3
) (
   input  logic                        clock,
   input  logic signed [WIDTH-1:0]     op_a,
   input  logic signed [WIDTH-1:0]     op_b,
   output logic signed [2*WIDTH-1:0]   product
);

   logic signed [2*WIDTH-1:0] product_ff;
   logic signed [2*WIDTH-1:0] product_in;

   // one product per cycle
   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== hdl/epg_emit.sv =====
// output stage: holds one step's four mirrored points and hands them out in order
module epg_emit #(
   parameter int COORD_BITS = epg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [COORD_BITS-1:0]         center_x,
   input  logic [COORD_BITS-1:0]         center_y,
   input  logic signed [COORD_BITS+1:0]  step_x,
   input  logic signed [COORD_BITS+1:0]  step_y,
   input  logic                          ends,
   output logic                          busy,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // pixel_x, pixel_y
   output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   // finished
   output logic                          rsp_tuser
);

   localparam int XW      = COORD_BITS + 2;
   localparam int OUT_PAD = ((2 * XW + 7) / 8) * 8;

   logic signed [XW-1:0] cx_ext;
   logic signed [XW-1:0] cy_ext;
   logic signed [XW-1:0] xp_ff, xm_ff, yp_ff, ym_ff;
   logic signed [XW-1:0] xp_in, xm_in, yp_in, ym_in;
   logic                 ends_ff, ends_in;
   logic                 valid_ff, valid_in;
   logic [1:0]           idx_ff, idx_in;
   logic signed [XW-1:0] pix_x, pix_y;

   // mirrored coordinates, wrapped to the output width
   assign cx_ext = $signed({2'b00, center_x});
   assign cy_ext = $signed({2'b00, center_y});
   assign xp_in  = cx_ext + step_x;
   assign xm_in  = cx_ext - step_x;
   assign yp_in  = cy_ext + step_y;
   assign ym_in  = cy_ext - step_y;
   assign ends_in = ends;

   // point counter and valid flag
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (valid_ff && rsp_tready) begin
         if (idx_ff == epg_pkg::LAST_POINT) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // point payload, captured on load
   always_ff @(posedge clock) begin
      if (load) begin
         xp_ff   <= xp_in;
         xm_ff   <= xm_in;
         yp_ff   <= yp_in;
         ym_ff   <= ym_in;
         ends_ff <= ends_in;
      end
   end

   // order: +x+y, -x+y, +x-y, -x-y
   assign pix_x = idx_ff[0] ? xm_ff : xp_ff;
   assign pix_y = idx_ff[1] ? ym_ff : yp_ff;

   assign busy       = valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = OUT_PAD'({pix_y, pix_x});
   assign rsp_tlast  = (idx_ff == epg_pkg::LAST_POINT);
   assign rsp_tuser  = (idx_ff == epg_pkg::LAST_POINT) && ends_ff;

endmodule

// ===== hdl/ellipse_point_generator.sv =====
// midpoint ellipse point generator: sequencer, decision datapath and output stage
//
// Request channel (req_): tuser is the action, 0 starts an ellipse and 1 asks
// for the next step; tdata carries center x, center y, radius x, radius y.
// Result channel (rsp_): each step of a running ellipse gives four points,
// pixel_x and pixel_y in tdata, tlast on the fourth point, tuser on the very
// last point of the ellipse. Steps while no ellipse runs give nothing.
// Start: from acceptance through the start terms to ready, and on through the
// region-two entry terms when the ellipse is flat and goes straight to region
// two. Step: accept, hand-off to the output stage, three decision updates, and
// the entry terms on the step that crosses into region two. All products go
// through one multiplier with a registered output and all decision updates
// through one accumulator adder. The first point of a step leaves the cycle
// after the hand-off, one point per cycle after that while rsp_tready is high.
// The output stage holds a whole step, so a new item is accepted while points
// wait; a step item waits at the hand-off until the previous four points are
// taken, so a stalled receiver backs up into req_tready.
// Reset clears the sequencer and the output stage; no ellipse runs afterwards.
module ellipse_point_generator #(
   parameter int COORD_BITS = epg_pkg::COORD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // center_x, center_y, radius_x, radius_y
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // action
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pixel_x, pixel_y
   output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // last_of_step
   output logic rsp_tlast,
   // finished
   output logic rsp_tuser
);

   localparam int C   = COORD_BITS;
   localparam int XW  = C + 2;
   localparam int SQW = 2 * C;
   localparam int MW  = 2 * C + 3;
   localparam int DW  = 2 * MW;

   epg_pkg::seq_state_type state_ff, state_in;
   epg_pkg::phase_type     phase_ff, phase_in;
   epg_pkg::add_op_type    add_sel;

   logic [C-1:0]          cx_ff, cx_in, cy_ff, cy_in;
   logic [C-1:0]          rx_ff, rx_in, ry_ff, ry_in;
   logic [SQW-1:0]        rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic signed [XW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [DW-1:0]  px_ff, px_in, py_ff, py_in;
   logic signed [DW-1:0]  dec_ff, dec_in;
   logic                  branch_ff, branch_in;

   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [DW-1:0]  prod;
   logic signed [DW-1:0]  addend, dec_sum;
   logic signed [DW-1:0]  rx2_ext, ry2_ext, rx2_dbl, ry2_dbl;
   logic signed [MW-1:0]  rx_m, ry_m, rx2_m, ry2_m, x_m, xp1_m, ym1_m, prod_m;
   logic signed [XW-1:0]  x_inc, y_dec;
   logic                  req_accept, emit_load, emit_busy, step_ends;
   logic                  dec_neg, dec_zero;

   assign req_tready = (state_ff == epg_pkg::ST_READY);
   assign req_accept = req_tvalid && req_tready;

   // operand forms
   assign x_inc   = x_ff + XW'(1);
   assign y_dec   = y_ff - XW'(1);
   assign rx2_ext = $signed({{(DW-SQW){1'b0}}, rx2_ff});
   assign ry2_ext = $signed({{(DW-SQW){1'b0}}, ry2_ff});
   assign rx2_dbl = $signed({{(DW-SQW-1){1'b0}}, rx2_ff, 1'b0});
   assign ry2_dbl = $signed({{(DW-SQW-1){1'b0}}, ry2_ff, 1'b0});
   assign rx_m    = $signed({{(MW-C){1'b0}}, rx_ff});
   assign ry_m    = $signed({{(MW-C){1'b0}}, ry_ff});
   assign rx2_m   = $signed({{(MW-SQW){1'b0}}, rx2_ff});
   assign ry2_m   = $signed({{(MW-SQW){1'b0}}, ry2_ff});
   assign x_m     = $signed({{(MW-XW){x_ff[XW-1]}}, x_ff});
   assign xp1_m   = $signed({{(MW-XW){x_inc[XW-1]}}, x_inc});
   assign ym1_m   = $signed({{(MW-XW){y_dec[XW-1]}}, y_dec});
   assign prod_m  = prod[MW-1:0];
   assign dec_neg  = dec_ff[DW-1];
   assign dec_zero = (dec_ff == '0);
   // the step that takes y below zero ends the ellipse
   assign step_ends = (phase_ff == epg_pkg::PH_R2) && (y_ff[XW-1] || (y_ff == '0));

   // shared multiplier
   epg_mult #(
      .WIDTH (MW)
   ) u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   // output stage
   epg_emit #(
      .COORD_BITS (COORD_BITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (emit_load),
      .center_x   (cx_ff),
      .center_y   (cy_ff),
      .step_x     (x_ff),
      .step_y     (y_ff),
      .ends       (step_ends),
      .busy       (emit_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // sequencer: next state, multiplier operands and accumulator operation
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rx2_in    = rx2_ff;
      ry2_in    = ry2_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      branch_in = branch_ff;
      mul_a     = '0;
      mul_b     = '0;
      add_sel   = epg_pkg::ADD_HOLD;
      emit_load = 1'b0;
      case (state_ff)
         epg_pkg::ST_READY: begin
            if (req_accept) begin
               if (req_tuser == epg_pkg::ACT_START) begin
                  cx_in    = req_tdata[C-1:0];
                  cy_in    = req_tdata[2*C-1:C];
                  rx_in    = req_tdata[3*C-1:2*C];
                  ry_in    = req_tdata[4*C-1:3*C];
                  x_in     = '0;
                  y_in     = $signed({2'b00, req_tdata[4*C-1:3*C]});
                  px_in    = '0;
                  phase_in = epg_pkg::PH_IDLE;
                  state_in = epg_pkg::ST_S_RX2;
               end else if (phase_ff == epg_pkg::PH_R1 || phase_ff == epg_pkg::PH_R2) begin
                  state_in = epg_pkg::ST_STEP_LOAD;
               end
            end
         end
         // start: squares, then the region-one decision in quarter units
         epg_pkg::ST_S_RX2: begin
            mul_a    = rx_m;
            mul_b    = rx_m;
            add_sel  = epg_pkg::ADD_ZERO;
            state_in = epg_pkg::ST_S_RY2;
         end
         epg_pkg::ST_S_RY2: begin
            rx2_in   = prod[SQW-1:0];
            mul_a    = ry_m;
            mul_b    = ry_m;
            add_sel  = epg_pkg::ADD_PROD;
            state_in = epg_pkg::ST_S_T;
         end
         epg_pkg::ST_S_T: begin
            ry2_in   = prod[SQW-1:0];
            mul_a    = rx2_m;
            mul_b    = ry_m;
            add_sel  = epg_pkg::ADD_PROD4;
            state_in = epg_pkg::ST_S_P;
         end
         epg_pkg::ST_S_P: begin
            py_in    = prod <<< 1;
            add_sel  = epg_pkg::ADD_NEG_PROD4;
            state_in = epg_pkg::ST_S_DIV;
         end
         epg_pkg::ST_S_DIV: begin
            add_sel = epg_pkg::ADD_DIV;
            if (px_ff < py_ff) begin
               phase_in = epg_pkg::PH_R1;
               state_in = epg_pkg::ST_READY;
            end else begin
               state_in = epg_pkg::ST_E_A;
            end
         end
         // hand the current point to the output stage
         epg_pkg::ST_STEP_LOAD: begin
            if (!emit_busy) begin
               emit_load = 1'b1;
               state_in  = (phase_ff == epg_pkg::PH_R1) ? epg_pkg::ST_R1_A
                                                        : epg_pkg::ST_R2_A;
            end
         end
         // region one step
         epg_pkg::ST_R1_A: begin
            x_in      = x_inc;
            px_in     = px_ff + ry2_dbl;
            branch_in = dec_neg;
            if (!dec_neg) begin
               y_in  = y_dec;
               py_in = py_ff - rx2_dbl;
            end
            add_sel  = epg_pkg::ADD_RY2;
            state_in = epg_pkg::ST_R1_B;
         end
         epg_pkg::ST_R1_B: begin
            add_sel  = epg_pkg::ADD_PX;
            state_in = epg_pkg::ST_R1_C;
         end
         epg_pkg::ST_R1_C: begin
            if (!branch_ff) begin
               add_sel = epg_pkg::ADD_NEG_PY;
            end
            state_in = (px_ff < py_ff) ? epg_pkg::ST_READY : epg_pkg::ST_E_A;
         end
         // region two step
         epg_pkg::ST_R2_A: begin
            y_in      = y_dec;
            py_in     = py_ff - rx2_dbl;
            branch_in = dec_neg || dec_zero;
            if (dec_neg || dec_zero) begin
               x_in  = x_inc;
               px_in = px_ff + ry2_dbl;
            end
            add_sel  = epg_pkg::ADD_RX2;
            state_in = epg_pkg::ST_R2_B;
         end
         epg_pkg::ST_R2_B: begin
            add_sel  = epg_pkg::ADD_NEG_PY;
            state_in = epg_pkg::ST_R2_C;
         end
         epg_pkg::ST_R2_C: begin
            if (branch_ff) begin
               add_sel = epg_pkg::ADD_PX;
            end
            if (y_ff[XW-1]) begin
               phase_in = epg_pkg::PH_IDLE;
            end
            state_in = epg_pkg::ST_READY;
         end
         // region-two entry decision in quarter units
         epg_pkg::ST_E_A: begin
            mul_a    = x_m;
            mul_b    = xp1_m;
            add_sel  = epg_pkg::ADD_ZERO;
            state_in = epg_pkg::ST_E_B;
         end
         epg_pkg::ST_E_B: begin
            mul_a    = ry2_m;
            mul_b    = prod_m;
            add_sel  = epg_pkg::ADD_RY2;
            state_in = epg_pkg::ST_E_C;
         end
         epg_pkg::ST_E_C: begin
            mul_a    = ym1_m;
            mul_b    = ym1_m;
            add_sel  = epg_pkg::ADD_PROD4;
            state_in = epg_pkg::ST_E_D;
         end
         epg_pkg::ST_E_D: begin
            mul_a    = rx2_m;
            mul_b    = prod_m;
            state_in = epg_pkg::ST_E_E;
         end
         epg_pkg::ST_E_E: begin
            mul_a    = rx2_m;
            mul_b    = ry2_m;
            add_sel  = epg_pkg::ADD_PROD4;
            state_in = epg_pkg::ST_E_F;
         end
         epg_pkg::ST_E_F: begin
            add_sel  = epg_pkg::ADD_NEG_PROD4;
            state_in = epg_pkg::ST_E_G;
         end
         epg_pkg::ST_E_G: begin
            add_sel  = epg_pkg::ADD_DIV;
            phase_in = epg_pkg::PH_R2;
            state_in = epg_pkg::ST_READY;
         end
         default: begin
            state_in = epg_pkg::ST_READY;
         end
      endcase
   end

   // decision accumulator: one adder, quarter-unit divide truncates toward zero
   always_comb begin
      case (add_sel)
         epg_pkg::ADD_RX2:       addend = rx2_ext;
         epg_pkg::ADD_RY2:       addend = ry2_ext;
         epg_pkg::ADD_PX:        addend = px_ff;
         epg_pkg::ADD_NEG_PY:    addend = -py_ff;
         epg_pkg::ADD_PROD:      addend = prod;
         epg_pkg::ADD_PROD4:     addend = prod <<< 2;
         epg_pkg::ADD_NEG_PROD4: addend = -(prod <<< 2);
         epg_pkg::ADD_DIV:       addend = dec_neg ? $signed({{(DW-2){1'b0}}, 2'b11}) : '0;
         default:                addend = '0;
      endcase
   end

   assign dec_sum = dec_ff + addend;

   always_comb begin
      case (add_sel)
         epg_pkg::ADD_HOLD: dec_in = dec_ff;
         epg_pkg::ADD_ZERO: dec_in = '0;
         epg_pkg::ADD_DIV:  dec_in = dec_sum >>> 2;
         default:           dec_in = dec_sum;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= epg_pkg::ST_READY;
         phase_ff <= epg_pkg::PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      rx2_ff    <= rx2_in;
      ry2_ff    <= ry2_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      dec_ff    <= dec_in;
      branch_ff <= branch_in;
   end

endmodule

// ===== hdl/epg_checker.sv =====
// port-level checks of the ellipse point generator and their binding
`include "ellipse_point_generator_assert.svh"

module epg_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast,
   input logic rsp_tuser
);

   // a stalled result item keeps its markers
   `EPG_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tlast) && $stable(rsp_tuser))

   // the end of the ellipse falls on the fourth point of a step
   `EPG_ASSERT(a_finish_on_last, rsp_tvalid && rsp_tuser |-> rsp_tlast)

   // a start item keeps the input closed while the start terms are formed
   `EPG_ASSERT(a_start_busy, req_tvalid && req_tready && req_tuser == epg_pkg::ACT_START |=> !req_tready)

   // nothing is offered right after reset
   `EPG_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid)

endmodule

bind ellipse_point_generator epg_checker u_epg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
